@@ design/bmtd_pkg.sv @@
// shared constants, types and register codes for the block mean threshold downsampler
`timescale 1ns / 1ps
`default_nettype none

package bmtd_pkg;

  // image geometry
  localparam int GRID_CELLS = 64;
  localparam int MAX_BLOCK  = 16;

  // widths derived from the geometry
  localparam int CELL_W = $clog2(GRID_CELLS);
  localparam int PIX_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int BS_W   = 5;
  localparam int CMP_W  = (PIX_W > BS_W) ? PIX_W : BS_W;
  localparam int SQ_W   = 2 * BS_W;
  localparam int PIX_VAL_W = 32;
  localparam int SUM_W  = PIX_VAL_W + 2 * $clog2(MAX_BLOCK);
  localparam int PROD_W = PIX_VAL_W + SQ_W;
  localparam int XY_W   = 6;

  // register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [BS_W-1:0]      BLOCK_SIZE_RST = BS_W'(16);
  localparam logic [PIX_VAL_W-1:0] THRESHOLD_RST  = PIX_VAL_W'(8);

  typedef enum logic [0:0] {
    REG_BLOCK_SIZE = 1'b0,
    REG_THRESHOLD  = 1'b1
  } reg_idx_t;

  // input request
  typedef struct packed {
    logic [PIX_VAL_W-1:0] pixel_value;
    logic                 frame_start;
  } pix_req_t;

  // result request
  typedef struct packed {
    logic            cell_on;
    logic [XY_W-1:0] cell_x;
    logic [XY_W-1:0] cell_y;
    logic            row_last;
  } res_req_t;

  // where the current pixel falls, handed from the position tracker
  typedef struct packed {
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    logic              done;
    logic              row_last;
    logic [SQ_W-1:0]   bs_sq;
  } pos_info_t;

endpackage

`default_nettype wire

@@ design/block_mean_threshold_downsampler.sv @@
// top level: position tracking, accumulate pipeline and threshold compare
//
//  channel   dir  handshake                 payload
//  pix       in   pix_valid / pix_stall     pix_data  (bmtd_pkg::pix_req_t)
//  res       out  res_valid / res_stall     res_data  (bmtd_pkg::res_req_t)
//  apb       in   psel / penable / pready   paddr, pwdata, prdata
//
// one pixel per clock while pix_stall is low; a finished cell's result passes the stage 1, stage 2 and result registers
// accumulate read-modify-write uses a registered memory read, forwarded from the next stage
// reset clears counters, control and the accumulator valid bits
// pix_stall is high only while a result waits on res_stall
`timescale 1ns / 1ps
`default_nettype none

module block_mean_threshold_downsampler (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bmtd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bmtd_pkg::DATA_W-1:0]  pwdata,
  output logic      [bmtd_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         pix_valid,
  output logic                              pix_stall,
  input  wire bmtd_pkg::pix_req_t           pix_data,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output bmtd_pkg::res_req_t                res_data
);

  logic [bmtd_pkg::BS_W-1:0]      block_size;
  logic [bmtd_pkg::PIX_VAL_W-1:0] threshold;
  bmtd_pkg::pos_info_t            info;
  logic                           adv, accept;

  // stage 1: memory read data lines up with the pixel
  logic                           s1_valid, s1_start;
  logic [bmtd_pkg::PIX_VAL_W-1:0] s1_pix;
  bmtd_pkg::pos_info_t            s1_info;
  logic [bmtd_pkg::SUM_W-1:0]     rd_data, base, sum, wdata;
  logic [bmtd_pkg::PROD_W-1:0]    prod;
  logic                           fwd;

  // stage 2: sum and limit registered for the compare
  logic                           s2_valid, s2_done, s2_row_last;
  logic [bmtd_pkg::CELL_W-1:0]    s2_col, s2_row;
  logic [bmtd_pkg::SUM_W-1:0]     s2_sum, s2_limit, s2_wdata;

  bmtd_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .block_size (block_size),
    .threshold  (threshold)
  );

  // pipeline moves whenever the result slot is free or being taken
  assign adv       = !(res_valid && res_stall);
  assign pix_stall = !adv;
  assign accept    = pix_valid && adv;

  bmtd_position u_pos (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .frame_start (pix_data.frame_start),
    .block_size  (block_size),
    .info        (info)
  );

  bmtd_acc_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (info.col),
    .rd_data   (rd_data),
    .wr_en     (s1_valid && adv),
    .wr_addr   (s1_info.col),
    .wr_data   (wdata),
    .clear_all (accept && pix_data.frame_start)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pix_data.pixel_value;
      s1_start <= pix_data.frame_start;
      s1_info  <= info;
    end
  end

  // accumulate with forwarding from the write held in stage 2
  assign fwd   = s2_valid && (s2_col == s1_info.col);
  assign base  = s1_start ? '0 : (fwd ? s2_wdata : rd_data);
  assign sum   = base + bmtd_pkg::SUM_W'(s1_pix);
  assign wdata = s1_info.done ? '0 : sum;
  assign prod  = bmtd_pkg::PROD_W'(threshold) * bmtd_pkg::PROD_W'(s1_info.bs_sq);

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_sum      <= sum;
      s2_limit    <= bmtd_pkg::SUM_W'(prod);
      s2_wdata    <= wdata;
      s2_done     <= s1_info.done;
      s2_col      <= s1_info.col;
      s2_row      <= s1_info.row;
      s2_row_last <= s1_info.row_last;
    end
  end

  // threshold compare into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s2_valid && s2_done;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_done) begin
      res_data.cell_on  <= s2_sum >= s2_limit;
      res_data.cell_x   <= bmtd_pkg::XY_W'(s2_col);
      res_data.cell_y   <= bmtd_pkg::XY_W'(s2_row);
      res_data.row_last <= s2_row_last;
    end
  end

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_done && adv |=> res_valid)
    else $error("finished cell produced no result");

  a_row_last_col: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.row_last |->
      res_data.cell_x == bmtd_pkg::XY_W'(bmtd_pkg::GRID_CELLS - 1))
    else $error("row_last on a cell that is not the last column");

  a_fwd_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_valid && fwd && s2_done && !s1_start |-> base == '0)
    else $error("forwarded sum not cleared after a finished cell");

endmodule

`default_nettype wire

@@ design/bmtd_regs.sv @@
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module bmtd_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bmtd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bmtd_pkg::DATA_W-1:0]    pwdata,
  output logic      [bmtd_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  output logic      [bmtd_pkg::BS_W-1:0]      block_size,
  output logic      [bmtd_pkg::PIX_VAL_W-1:0] threshold
);

  bmtd_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = bmtd_pkg::reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= bmtd_pkg::BLOCK_SIZE_RST;
      threshold  <= bmtd_pkg::THRESHOLD_RST;
    end else if (wr) begin
      case (idx)
        bmtd_pkg::REG_BLOCK_SIZE: block_size <= pwdata[bmtd_pkg::BS_W-1:0];
        bmtd_pkg::REG_THRESHOLD:  threshold  <= pwdata[bmtd_pkg::PIX_VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      bmtd_pkg::REG_BLOCK_SIZE: prdata = bmtd_pkg::DATA_W'(block_size);
      bmtd_pkg::REG_THRESHOLD:  prdata = bmtd_pkg::DATA_W'(threshold);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/bmtd_position.sv @@
// pixel and cell position counters, one step per accepted pixel
`timescale 1ns / 1ps
`default_nettype none

module bmtd_position (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic                         frame_start,
  input  wire logic [bmtd_pkg::BS_W-1:0]    block_size,
  output bmtd_pkg::pos_info_t               info
);

  logic [bmtd_pkg::PIX_W-1:0]  pbx, pby, pbx_next, pby_next, cur_x, cur_y;
  logic [bmtd_pkg::CELL_W-1:0] cell_column, cell_row, cell_column_next, cell_row_next;
  logic [bmtd_pkg::CELL_W-1:0] cur_col, cur_row;
  logic [bmtd_pkg::BS_W-1:0]   bs;
  logic [bmtd_pkg::CMP_W-1:0]  bs_last;
  logic                        last_x, last_y, col_end;

  // effective block size, clamped to 1..MAX_BLOCK
  always_comb begin
    bs = block_size;
    if (block_size == '0) begin
      bs = bmtd_pkg::BS_W'(1);
    end
    if (int'(block_size) > bmtd_pkg::MAX_BLOCK) begin
      bs = bmtd_pkg::BS_W'(bmtd_pkg::MAX_BLOCK);
    end
  end

  // a frame start puts this pixel at the origin
  assign cur_x   = frame_start ? '0 : pbx;
  assign cur_y   = frame_start ? '0 : pby;
  assign cur_col = frame_start ? '0 : cell_column;
  assign cur_row = frame_start ? '0 : cell_row;

  assign bs_last = bmtd_pkg::CMP_W'(bs) - bmtd_pkg::CMP_W'(1);
  assign last_x  = bmtd_pkg::CMP_W'(cur_x) >= bs_last;
  assign last_y  = bmtd_pkg::CMP_W'(cur_y) >= bs_last;
  assign col_end = cur_col == bmtd_pkg::CELL_W'(bmtd_pkg::GRID_CELLS - 1);

  assign info.col      = cur_col;
  assign info.row      = cur_row;
  assign info.done     = last_x && last_y;
  assign info.row_last = col_end;
  assign info.bs_sq    = bmtd_pkg::SQ_W'(bs) * bmtd_pkg::SQ_W'(bs);

  // next position in raster order
  always_comb begin
    pbx_next         = cur_x;
    pby_next         = cur_y;
    cell_column_next = cur_col;
    cell_row_next    = cur_row;
    if (last_x) begin
      pbx_next = '0;
      if (col_end) begin
        cell_column_next = '0;
        if (last_y) begin
          pby_next = '0;
          if (cur_row == bmtd_pkg::CELL_W'(bmtd_pkg::GRID_CELLS - 1)) begin
            cell_row_next = '0;
          end else begin
            cell_row_next = cur_row + bmtd_pkg::CELL_W'(1);
          end
        end else begin
          pby_next = cur_y + bmtd_pkg::PIX_W'(1);
        end
      end else begin
        cell_column_next = cur_col + bmtd_pkg::CELL_W'(1);
      end
    end else begin
      pbx_next = cur_x + bmtd_pkg::PIX_W'(1);
    end
  end

  // position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pbx         <= '0;
      pby         <= '0;
      cell_column <= '0;
      cell_row    <= '0;
    end else if (step) begin
      pbx         <= pbx_next;
      pby         <= pby_next;
      cell_column <= cell_column_next;
      cell_row    <= cell_row_next;
    end
  end

endmodule

`default_nettype wire

@@ design/bmtd_acc_mem.sv @@
// column accumulator memory with per-entry valid bits, registered read
`timescale 1ns / 1ps
`default_nettype none

module bmtd_acc_mem (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [bmtd_pkg::CELL_W-1:0]   rd_addr,
  output logic      [bmtd_pkg::SUM_W-1:0]    rd_data,
  input  wire logic                          wr_en,
  input  wire logic [bmtd_pkg::CELL_W-1:0]   wr_addr,
  input  wire logic [bmtd_pkg::SUM_W-1:0]    wr_data,
  input  wire logic                          clear_all
);

  logic [bmtd_pkg::SUM_W-1:0]      mem [bmtd_pkg::GRID_CELLS];
  logic [bmtd_pkg::GRID_CELLS-1:0] vld;
  logic [bmtd_pkg::SUM_W-1:0]      rd_q;
  logic                            rd_vld;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // valid bits, a clear wins over a write in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (clear_all) begin
        vld <= '0;
      end else if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rd_data = rd_vld ? rd_q : '0;

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clear_all |=> $countones(vld) == 0)
    else $error("valid bits survive a clear");

  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    wr_en && !clear_all |=> vld[$past(wr_addr)])
    else $error("written entry not marked valid");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking testbench for the block mean threshold downsampler
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int RANDOM_ITEMS     = 320;
  localparam int RANDOM_PHASE_MAX = 160;
  localparam int ROWS_PIX         = 160;
  localparam int ROW_SPAN_PIX     = bmtd_pkg::GRID_CELLS * 2 * 2 + 8;

  // which registers a configuration step writes
  localparam logic [1:0] CFG_NONE = 2'b00;
  localparam logic [1:0] CFG_BS   = 2'b01;
  localparam logic [1:0] CFG_THR  = 2'b10;
  localparam logic [1:0] CFG_BOTH = 2'b11;

  localparam logic [bmtd_pkg::ADDR_W-1:0] BS_ADDR  =
    bmtd_pkg::ADDR_W'(4 * int'(bmtd_pkg::REG_BLOCK_SIZE));
  localparam logic [bmtd_pkg::ADDR_W-1:0] THR_ADDR =
    bmtd_pkg::ADDR_W'(4 * int'(bmtd_pkg::REG_THRESHOLD));

  typedef enum logic [1:0] {PIX_FULL, PIX_SMALL, PIX_EDGE, PIX_NEAR} pix_mode_t;

  // one pixel waiting to be sent, with an optional hand-written result
  typedef struct packed {
    bmtd_pkg::pix_req_t req;
    logic               typed;
    bmtd_pkg::res_req_t want;
  } pixel_job_t;

  // directed row: optional register writes, then one pixel
  typedef struct packed {
    logic [1:0]                     cfg;
    logic [bmtd_pkg::BS_W-1:0]      bs;
    logic [bmtd_pkg::PIX_VAL_W-1:0] thr;
    bmtd_pkg::pix_req_t             req;
    logic                           typed;
    bmtd_pkg::res_req_t             want;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [0:13] = '{
    // block size 1 with reset threshold 8
    '{CFG_BS,   5'd1,  32'd0,          '{32'd8,          1'b1}, 1'b1, '{1'b1, 6'd0, 6'd0, 1'b0}},
    '{CFG_NONE, 5'd0,  32'd0,          '{32'd7,          1'b0}, 1'b1, '{1'b0, 6'd1, 6'd0, 1'b0}},
    '{CFG_NONE, 5'd0,  32'd0,          '{32'd0,          1'b0}, 1'b1, '{1'b0, 6'd2, 6'd0, 1'b0}},
    '{CFG_NONE, 5'd0,  32'd0,          '{32'hFFFF_FFFF,  1'b0}, 1'b1, '{1'b1, 6'd3, 6'd0, 1'b0}},
    // frame start mid-row goes back to the first cell
    '{CFG_NONE, 5'd0,  32'd0,          '{32'd9,          1'b1}, 1'b1, '{1'b1, 6'd0, 6'd0, 1'b0}},
    // block size zero acts as one, threshold zero sets every cell
    '{CFG_BOTH, 5'd0,  32'd0,          '{32'd0,          1'b1}, 1'b1, '{1'b1, 6'd0, 6'd0, 1'b0}},
    '{CFG_NONE, 5'd0,  32'd0,          '{32'd0,          1'b0}, 1'b1, '{1'b1, 6'd1, 6'd0, 1'b0}},
    // largest threshold
    '{CFG_THR,  5'd0,  32'hFFFF_FFFF,  '{32'hFFFF_FFFF,  1'b0}, 1'b1, '{1'b1, 6'd2, 6'd0, 1'b0}},
    '{CFG_NONE, 5'd0,  32'd0,          '{32'hFFFF_FFFE,  1'b0}, 1'b1, '{1'b0, 6'd3, 6'd0, 1'b0}},
    '{CFG_NONE, 5'd0,  32'd0,          '{32'h8000_0000,  1'b0}, 1'b1, '{1'b0, 6'd4, 6'd0, 1'b0}},
    // start a large cell, then shrink the block size mid-image
    '{CFG_BOTH, 5'd16, 32'd3,          '{32'd3,          1'b1}, 1'b0, '0},
    '{CFG_NONE, 5'd0,  32'd0,          '{32'd4,          1'b0}, 1'b0, '0},
    '{CFG_BS,   5'd1,  32'd0,          '{32'd0,          1'b0}, 1'b0, '0},
    '{CFG_NONE, 5'd0,  32'd0,          '{32'd2,          1'b0}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [bmtd_pkg::ADDR_W-1:0]    paddr   = '0;
  logic [bmtd_pkg::DATA_W-1:0]    pwdata  = '0;
  logic [bmtd_pkg::DATA_W-1:0]    prdata;
  logic                           pready;
  logic                           pix_valid = 1'b0;
  logic                           pix_stall;
  bmtd_pkg::pix_req_t             pix_data  = '0;
  logic                           res_valid;
  logic                           res_stall = 1'b0;
  bmtd_pkg::res_req_t             res_data;

  // predictor state and its copy of the registers
  logic [63:0]                    col_acc [bmtd_pkg::GRID_CELLS];
  int unsigned                    sub_x, sub_y, cell_col, cell_row;
  logic [bmtd_pkg::BS_W-1:0]      cfg_block  = bmtd_pkg::BLOCK_SIZE_RST;
  logic [bmtd_pkg::PIX_VAL_W-1:0] cfg_thresh = bmtd_pkg::THRESHOLD_RST;

  pixel_job_t          pixel_plan [$];
  bmtd_pkg::res_req_t  pending_cells [$];
  pixel_job_t          in_flight;
  int                  pixels_queued = 0;
  int                  pixels_taken  = 0;
  int                  mismatches    = 0;
  int                  burst_left    = 0;
  int                  gap_left      = 0;
  int                  stall_hold    = 0;
  int                  idle_cycles   = 0;

  block_mean_threshold_downsampler DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    foreach (col_acc[i]) col_acc[i] = '0;
    sub_x = 0;
    sub_y = 0;
    cell_col = 0;
    cell_row = 0;
  end

  // accumulate one pixel into its column and decide the finished cell, if any
  function automatic void accumulate_pixel(input bmtd_pkg::pix_req_t req, output bit done,
                                           output bmtd_pkg::res_req_t closed);
    int unsigned bs, col;
    bit          lx, ly;
    logic [63:0] limit;
    bs = cfg_block;
    if (bs == 0) bs = 1;
    if (bs > bmtd_pkg::MAX_BLOCK) bs = bmtd_pkg::MAX_BLOCK;
    if (req.frame_start) begin
      foreach (col_acc[i]) col_acc[i] = '0;
      sub_x = 0;
      sub_y = 0;
      cell_col = 0;
      cell_row = 0;
    end
    col = cell_col;
    if (col >= bmtd_pkg::GRID_CELLS) col = bmtd_pkg::GRID_CELLS - 1;
    col_acc[col] += 64'(req.pixel_value);
    lx = sub_x >= bs - 1;
    ly = sub_y >= bs - 1;
    done = 1'b0;
    closed = '0;
    // bottom-right pixel closes the cell
    if (lx && ly) begin
      limit = 64'(cfg_thresh) * 64'(bs * bs);
      closed.cell_on  = col_acc[col] >= limit;
      closed.cell_x   = bmtd_pkg::XY_W'(col);
      closed.cell_y   = bmtd_pkg::XY_W'(cell_row);
      closed.row_last = col == bmtd_pkg::GRID_CELLS - 1;
      col_acc[col] = '0;
      done = 1'b1;
    end
    // advance the raster position
    if (lx) begin
      sub_x = 0;
      if (col >= bmtd_pkg::GRID_CELLS - 1) begin
        cell_col = 0;
        if (ly) begin
          sub_y = 0;
          cell_row = (cell_row >= bmtd_pkg::GRID_CELLS - 1) ? 0 : cell_row + 1;
        end else begin
          sub_y++;
        end
      end else begin
        cell_col = col + 1;
      end
    end else begin
      sub_x++;
    end
  endfunction

  function automatic logic [bmtd_pkg::PIX_VAL_W-1:0] pick_pixel(input pix_mode_t mode);
    longint v;
    int     off;
    case (mode)
      PIX_SMALL: begin
        if ($urandom_range(0, 63) == 0) v = $urandom;
        else v = $urandom_range(0, 16);
      end
      PIX_EDGE: begin
        case ($urandom_range(0, 2))
          0:       v = 0;
          1:       v = 32'hFFFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      PIX_NEAR: begin
        off = int'($urandom_range(0, 4)) - 2;
        v = longint'(cfg_thresh) + off;
        if (v < 0) v = 0;
        if (v > 64'h0_FFFF_FFFF) v = 64'h0_FFFF_FFFF;
      end
      default: v = $urandom;
    endcase
    return v[bmtd_pkg::PIX_VAL_W-1:0];
  endfunction

  task automatic queue_pixel(input bmtd_pkg::pix_req_t req, input logic typed,
                             input bmtd_pkg::res_req_t want);
    pixel_job_t job;
    job.req = req;
    job.typed = typed;
    job.want = want;
    pixel_plan.push_back(job);
    pixels_queued++;
  endtask

  // wait until every pixel is in and every result is out, then let the pipe settle
  task automatic drain_block();
    while (pixels_taken != pixels_queued || pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [bmtd_pkg::ADDR_W-1:0] addr,
                           input logic [bmtd_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_regs(input logic [1:0] which, input logic [bmtd_pkg::BS_W-1:0] bs,
                              input logic [bmtd_pkg::PIX_VAL_W-1:0] thr);
    drain_block();
    if ((which & CFG_BS) != CFG_NONE) begin
      apb_write(BS_ADDR, bmtd_pkg::DATA_W'(bs));
      cfg_block = bs;
    end
    if ((which & CFG_THR) != CFG_NONE) begin
      apb_write(THR_ADDR, thr);
      cfg_thresh = thr;
    end
  endtask

  task automatic run_phase(input logic [1:0] which, input logic [bmtd_pkg::BS_W-1:0] bs,
                           input logic [bmtd_pkg::PIX_VAL_W-1:0] thr, input int count,
                           input bit fs_first, input pix_mode_t mode);
    bmtd_pkg::pix_req_t req;
    program_regs(which, bs, thr);
    for (int k = 0; k < count; k++) begin
      req.pixel_value = pick_pixel(mode);
      req.frame_start = (k == 0) ? fs_first : ($urandom_range(0, 299) == 0);
      queue_pixel(req, 1'b0, '0);
    end
  endtask

  task automatic report_cell(input string what, input bmtd_pkg::res_req_t want,
                             input bmtd_pkg::res_req_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected on=%0b x=%0d y=%0d last=%0b, got on=%0b x=%0d y=%0d last=%0b",
               what, want.cell_on, want.cell_x, want.cell_y, want.row_last,
               got.cell_on, got.cell_x, got.cell_y, got.row_last);
  endtask

  // pixel sender: bursts with gaps, predicts on every accepted request
  always @(posedge clk) begin
    bit                 done;
    bmtd_pkg::res_req_t closed;
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && !pix_stall) begin
        accumulate_pixel(in_flight.req, done, closed);
        if (in_flight.typed) pending_cells.push_back(in_flight.want);
        else if (done) pending_cells.push_back(closed);
        pixels_taken++;
      end
      if (!pix_valid || !pix_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_valid <= 1'b0;
        end else if (pixel_plan.size() != 0) begin
          in_flight = pixel_plan.pop_front();
          pix_valid <= 1'b1;
          pix_data <= in_flight.req;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
              burst_left = $urandom_range(100, 400);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left = $urandom_range(0, 10);
            end
          end
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // result stall pattern: free stretches, choppy cycles, solid blocks
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          res_stall <= 1'b0;
          stall_hold = $urandom_range(5, 60);
        end
        4, 5, 6: begin
          res_stall <= 1'($urandom_range(0, 1));
        end
        default: begin
          res_stall <= 1'b1;
          stall_hold = $urandom_range(1, 20);
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    bmtd_pkg::res_req_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_cells.size() == 0) begin
        report_cell("unexpected result", '0, res_data);
      end else begin
        want = pending_cells.pop_front();
        if (res_data.cell_on !== want.cell_on || res_data.cell_x !== want.cell_x ||
            res_data.cell_y !== want.cell_y || res_data.row_last !== want.row_last)
          report_cell("result mismatch", want, res_data);
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[block_mean_threshold_downsampler] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                        rand_items;
    int                        eff, len, pick;
    logic [bmtd_pkg::BS_W-1:0] bs_pick;
    logic [31:0]               thr_pick;
    rand_items = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].cfg != CFG_NONE)
        program_regs(DIRECTED_ROWS[i].cfg, DIRECTED_ROWS[i].bs, DIRECTED_ROWS[i].thr);
      queue_pixel(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // oversized block sizes saturate; shrinking afterwards shows the kept position
    run_phase(CFG_BS, 5'd31, 32'd0, 40, 1'b1, PIX_FULL);
    run_phase(CFG_BS, 5'd1, 32'd0, 30, 1'b0, PIX_NEAR);
    run_phase(CFG_BS, 5'd17, 32'd0, 40, 1'b1, PIX_EDGE);
    run_phase(CFG_BS, 5'd1, 32'd0, 30, 1'b0, PIX_FULL);

    // several cell rows at block size 1
    run_phase(CFG_BOTH, 5'd1, $urandom_range(0, 16), ROWS_PIX, 1'b1, PIX_SMALL);

    // one full cell row at block size 2
    run_phase(CFG_BOTH, 5'd2, 32'd8, ROW_SPAN_PIX, 1'b1, PIX_SMALL);

    // random phases, mostly small blocks
    while (rand_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) bs_pick = 5'd1;
      else if (pick < 12) bs_pick = 5'd2;
      else if (pick < 14) bs_pick = 5'd3;
      else if (pick < 15) bs_pick = 5'd4;
      else if (pick < 17) bs_pick = 5'd0;
      else if (pick < 18) bs_pick = bmtd_pkg::BS_W'($urandom_range(5, 16));
      else bs_pick = bmtd_pkg::BS_W'($urandom_range(17, 31));
      case ($urandom_range(0, 5))
        0:       thr_pick = 32'd0;
        1:       thr_pick = 32'hFFFF_FFFF;
        2, 3:    thr_pick = $urandom_range(0, 20);
        4:       thr_pick = $urandom;
        default: thr_pick = $urandom_range(32'h3FFF_FFF0, 32'h4000_0010);
      endcase
      eff = (bs_pick == 0) ? 1 :
            ((bs_pick > bmtd_pkg::MAX_BLOCK) ? bmtd_pkg::MAX_BLOCK : int'(bs_pick));
      len = $urandom_range(8 * eff * eff, 128 * eff * eff);
      if (len > RANDOM_PHASE_MAX) len = RANDOM_PHASE_MAX;
      run_phase(2'($urandom_range(1, 3)), bs_pick, thr_pick, len,
                1'($urandom_range(0, 1)), pix_mode_t'($urandom_range(0, 3)));
      rand_items += len;
    end

    drain_block();
    if (mismatches == 0) begin
      $display("[block_mean_threshold_downsampler] OK");
    end else begin
      $display("[block_mean_threshold_downsampler] ERROR");
    end
    $finish;
  end

endmodule

@@ block_mean_threshold_downsampler.f @@
design/bmtd_pkg.sv
design/bmtd_regs.sv
design/bmtd_position.sv
design/bmtd_acc_mem.sv
design/block_mean_threshold_downsampler.sv
bench/testbench.sv
